// ===== rtl/core/msbp_pkg.sv =====
// Shared types and constants of the MSB-first bit packer.
package msbp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned ACC_W     = BYTE_W - 1;
  localparam int unsigned VAL_W     = DATA_W + ACC_W;
  localparam int unsigned TOT_W     = 6;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QAW       = 1;
  localparam int unsigned QCW       = 2;

  localparam logic [CNT_W-1:0] MAX_FIELD = CNT_W'(DATA_W);
  localparam logic [TOT_W-1:0] TOT_BYTE  = TOT_W'(BYTE_W);
  localparam logic [TOT_W-1:0] TOT_TWO   = TOT_W'(2 * BYTE_W);
  localparam logic [TOT_W-1:0] TOT_MAX   = TOT_W'(VAL_W);

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] data;
  } entry_t;

endpackage

// ===== rtl/core/msbp_front.sv =====
// Front end of the bit packer: accepts input words and normalizes them.
module msbp_front (
  input  logic                          push,
  input  logic                          q_full_i,
  input  logic                          cmd_i,
  input  logic [msbp_pkg::CNT_W-1:0]    bit_count_i,
  input  logic [msbp_pkg::DATA_W-1:0]   data_bits_i,
  output logic                          wr_en_o,
  output msbp_pkg::entry_t              wr_entry_o
);

  logic [msbp_pkg::CNT_W-1:0]  cnt_sat;
  logic [msbp_pkg::DATA_W:0]   mask_ext;
  msbp_pkg::cmd_e              cmd;

  assign cmd     = msbp_pkg::cmd_e'(cmd_i);
  assign wr_en_o = push && !q_full_i;

  // Counts above the field width saturate; unused data bits are cleared.
  assign cnt_sat  = (bit_count_i > msbp_pkg::MAX_FIELD) ? msbp_pkg::MAX_FIELD : bit_count_i;
  assign mask_ext = ((msbp_pkg::DATA_W+1)'(1) << cnt_sat) - (msbp_pkg::DATA_W+1)'(1);

  always_comb begin
    wr_entry_o.cmd = cmd;
    unique case (cmd)
      msbp_pkg::CMD_FINISH: begin
        wr_entry_o.cnt  = '0;
        wr_entry_o.data = '0;
      end
      default: begin
        wr_entry_o.cnt  = cnt_sat;
        wr_entry_o.data = data_bits_i & mask_ext[msbp_pkg::DATA_W-1:0];
      end
    endcase
  end

endmodule

// ===== rtl/core/msbp_queue.sv =====
// Short command queue between the front end and the byte emitter.
module msbp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  msbp_pkg::entry_t  wr_entry_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output logic              rd_valid_o,
  output msbp_pkg::entry_t  rd_entry_o
);

  msbp_pkg::entry_t            mem_q [msbp_pkg::QDEPTH];
  logic [msbp_pkg::QAW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [msbp_pkg::QAW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [msbp_pkg::QCW-1:0]    cnt_q, cnt_d;
  logic                        do_wr, do_rd;

  assign full_o     = (cnt_q == msbp_pkg::QCW'(msbp_pkg::QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + msbp_pkg::QAW'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + msbp_pkg::QAW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + msbp_pkg::QCW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - msbp_pkg::QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= msbp_pkg::QCW'(msbp_pkg::QDEPTH))
    else $error("queue fill count above depth");
  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + msbp_pkg::QCW'(1)))
    else $error("queue fill count did not follow a lone write");
`endif

endmodule

// ===== rtl/core/msbp_back.sv =====
// Back end of the bit packer: merges fields with pending bits and emits bytes.
module msbp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  msbp_pkg::entry_t             q_entry_i,
  output logic                         q_pop_o,
  input  logic                         pop,
  output logic                         empty,
  output logic [msbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                         last_o
);

  // val_q holds tot_q valid bits right-aligned, oldest bit highest. When
  // tot_q is below a byte, these are the pending bits of the partial byte.
  logic [msbp_pkg::VAL_W-1:0]   val_q, val_d;
  logic [msbp_pkg::TOT_W-1:0]   tot_q, tot_d;
  logic                         ov_q, ov_d;
  logic [msbp_pkg::BYTE_W-1:0]  byte_q, byte_d;
  logic                         last_q, last_d;

  logic                         out_free, emit, load;
  logic [msbp_pkg::ACC_W-1:0]   acc;
  logic [2:0]                   have;
  logic [msbp_pkg::VAL_W-1:0]   shifted;
  logic [14:0]                  pad_ext;

  assign acc      = val_q[msbp_pkg::ACC_W-1:0];
  assign have     = tot_q[2:0];
  assign out_free = !ov_q || pop;
  assign emit     = (tot_q >= msbp_pkg::TOT_BYTE) && out_free;
  assign load     = (tot_q < msbp_pkg::TOT_BYTE) && q_valid_i;
  assign q_pop_o  = load;

  assign shifted  = val_q >> (tot_q - msbp_pkg::TOT_BYTE);
  assign pad_ext  = {8'b0, acc} << (4'd8 - {1'b0, have});

  always_comb begin
    val_d  = val_q;
    tot_d  = tot_q;
    ov_d   = ov_q;
    byte_d = byte_q;
    last_d = last_q;
    if (emit) begin
      ov_d   = 1'b1;
      byte_d = shifted[msbp_pkg::BYTE_W-1:0];
      last_d = (tot_q < msbp_pkg::TOT_TWO);
      tot_d  = tot_q - msbp_pkg::TOT_BYTE;
    end else if (pop) begin
      ov_d = 1'b0;
    end
    if (load) begin
      unique case (q_entry_i.cmd)
        msbp_pkg::CMD_FINISH: begin
          val_d = {{(msbp_pkg::VAL_W-msbp_pkg::BYTE_W){1'b0}}, pad_ext[7:0]};
          tot_d = (have != 3'd0) ? msbp_pkg::TOT_BYTE : '0;
        end
        default: begin
          val_d = ({{msbp_pkg::DATA_W{1'b0}}, acc} << q_entry_i.cnt)
                | {{msbp_pkg::ACC_W{1'b0}}, q_entry_i.data};
          tot_d = {3'b0, have} + q_entry_i.cnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      tot_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      val_q <= val_d;
      tot_q <= tot_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign empty      = !ov_q;
  assign out_byte_o = byte_q;
  assign last_o     = last_q;

`ifndef NO_ASSERTIONS
  a_tot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q <= msbp_pkg::TOT_MAX)
    else $error("bit total above buffer width");
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> (tot_q < msbp_pkg::TOT_BYTE))
    else $error("final byte marked while a full byte remains");
`endif

endmodule

// ===== rtl/core/msb_first_bit_packer_unit.sv =====
// Top level of the MSB-first variable-length bit packer.
//
//  Channel  Direction  Handshake             Payload
//  input    in         push / full           cmd_i, bit_count_i, data_bits_i
//  result   out        empty / pop           out_byte_o, last_o
//
// The front end is combinational, so an accepted word enters a two-entry
// queue at the accepting edge. The back end then merges it with the pending
// bits in val_q and tot_q and emits the bytes it completes one after another;
// it takes no new word until fewer than eight bits remain, so the byte
// emitter sets the throughput. With the back end idle, the first byte passes
// the queue, the merge registers and the result register before it shows on
// the result ports. Reset clears the pending bits, the queue and the result
// valid flag. A stalled result (pop low) holds the emitter, while the queue
// keeps taking input words until it is full.
module msb_first_bit_packer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          cmd_i,
  input  logic [msbp_pkg::CNT_W-1:0]    bit_count_i,
  input  logic [msbp_pkg::DATA_W-1:0]   data_bits_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [msbp_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                          last_o
);

  // Front to queue: a write strobe and the normalized command word.
  logic              wr_en;
  msbp_pkg::entry_t  wr_entry;

  // Queue to back end: the oldest command and its release strobe.
  logic              q_valid;
  logic              q_pop;
  msbp_pkg::entry_t  q_entry;

  // The front end saturates the count and clears data bits that will not
  // be appended, so the back end only shifts and merges.
  msbp_front u_front (
    .push        (push),
    .q_full_i    (full),
    .cmd_i       (cmd_i),
    .bit_count_i (bit_count_i),
    .data_bits_i (data_bits_i),
    .wr_en_o     (wr_en),
    .wr_entry_o  (wr_entry)
  );

  // The queue decouples input acceptance from byte emission, so a stalled
  // result side does not stop input words from being taken.
  msbp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_entry_i (wr_entry),
    .full_o     (full),
    .rd_en_i    (q_pop),
    .rd_valid_o (q_valid),
    .rd_entry_o (q_entry)
  );

  // The back end owns the partial byte and the result register; it takes
  // a new command only once fewer than eight bits remain.
  msbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

// ===== dv/msb_first_bit_packer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench: MSB-first bit packer against a bit-serial packing model.
module msb_first_bit_packer_unit_tb;

  // Random words after the directed rows, and the settle time at the end.
  localparam int RAND_WORDS   = 360;
  localparam int SETTLE_ticks = 24;

  // One directed row. When typed is set, the bytes the row must produce are
  // spelled out in typed_bytes: n_typed bytes, the first one emitted being
  // the most significant of them. Otherwise the packing model decides.
  typedef struct packed {
    msbp_pkg::cmd_e              cmd;
    logic [msbp_pkg::CNT_W-1:0]  cnt;
    logic [msbp_pkg::DATA_W-1:0] data;
    logic                        typed;
    logic [2:0]                  n_typed;
    logic [31:0]                 typed_bytes;
  } stim_row_t;

  // One byte the block still owes us.
  typedef struct packed {
    logic [msbp_pkg::BYTE_W-1:0] value;
    logic                        last;
  } due_byte_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        push        = 1'b0;
  logic                        cmd_i       = 1'b0;
  logic [msbp_pkg::CNT_W-1:0]  bit_count_i = '0;
  logic [msbp_pkg::DATA_W-1:0] data_bits_i = '0;
  logic                        pop         = 1'b0;
  logic                        full;
  logic                        empty;
  logic [msbp_pkg::BYTE_W-1:0] out_byte_o;
  logic                        last_o;

  // Packing state of the model: bits not yet forming a whole byte, kept
  // right-aligned with the oldest bit highest, and how many there are.
  logic [msbp_pkg::ACC_W-1:0]  pend_bits = '0;
  logic [2:0]                  pend_cnt  = '0;

  due_byte_t         due_bytes_q[$];
  stim_row_t         stim_rows[$];
  int                mismatch_cnt = 0;

  msb_first_bit_packer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .bit_count_i (bit_count_i),
    .data_bits_i (data_bits_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always #4 clk_i = ~clk_i;

  // Reset is held at the start and never raised again.
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog. Even a slow but correct run, with every word making four
  // bytes and every byte waiting out the slowest pop pattern, stays far
  // below this bound.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Packs one word into the model state and returns how many bytes it
  // completes; made[i] is the i-th byte emitted. Bits are shifted in one at
  // a time, from bit count-1 down to bit 0 of the data.
  function automatic int pack_field(input msbp_pkg::cmd_e op,
                                    input logic [msbp_pkg::CNT_W-1:0] cnt,
                                    input logic [msbp_pkg::DATA_W-1:0] data,
                                    output logic [3:0][msbp_pkg::BYTE_W-1:0] made);
    logic [msbp_pkg::BYTE_W-1:0] acc;
    int unsigned                 have;
    int unsigned                 k;
    int                          n;
    acc  = {1'b0, pend_bits};
    have = 32'(pend_cnt);
    n    = 0;
    made = '0;
    if (op == msbp_pkg::CMD_FINISH) begin
      // Finish pads the pending bits with zeros on the right; with nothing
      // pending it emits nothing. Its count and data are don't-care.
      if (have != 0) begin
        made[0] = acc << (msbp_pkg::BYTE_W - have);
        n = 1;
      end
      pend_bits = '0;
      pend_cnt  = '0;
      return n;
    end
    // Counts beyond a full data word saturate at thirty-two bits.
    k = (cnt > msbp_pkg::MAX_FIELD) ? msbp_pkg::DATA_W : 32'(cnt);
    while (k > 0) begin
      k--;
      acc = {acc[msbp_pkg::BYTE_W-2:0], data[k]};
      have++;
      if (have == msbp_pkg::BYTE_W) begin
        made[n] = acc;
        n++;
        acc  = '0;
        have = 0;
      end
    end
    pend_bits = acc[msbp_pkg::ACC_W-1:0];
    pend_cnt  = have[2:0];
    return n;
  endfunction

  // Books the bytes an accepted word owes. The model always advances, so
  // its state stays right even on rows whose bytes are typed in by hand.
  task automatic book_word(input stim_row_t row);
    logic [3:0][msbp_pkg::BYTE_W-1:0] made;
    int                               n;
    due_byte_t                        due;
    n = pack_field(row.cmd, row.cnt, row.data, made);
    if (row.typed) begin
      n = int'(row.n_typed);
      for (int i = 0; i < n; i++)
        made[i] = row.typed_bytes[8*(n-1-i) +: 8];
    end
    for (int i = 0; i < n; i++) begin
      due.value = made[i];
      due.last  = (i == n - 1);
      due_bytes_q.push_back(due);
    end
  endtask

  // Presents one word and holds it until the block takes it. Push stays
  // high on return, so back-to-back words need no second assignment in
  // the same time step. The handshake is sampled on the edge itself, which
  // sees the values from before that edge.
  task automatic send_word(input stim_row_t row);
    push        <= 1'b1;
    cmd_i       <= row.cmd;
    bit_count_i <= row.cnt;
    data_bits_i <= row.data;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    book_word(row);
  endtask

  task automatic idle_ticks(input int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Holds off the sender until every booked byte has come out. It always
  // lets at least one edge pass, so the next drive lands in a later step.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (due_bytes_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_row(input msbp_pkg::cmd_e op, input logic [msbp_pkg::CNT_W-1:0] cnt,
                         input logic [msbp_pkg::DATA_W-1:0] data, input logic typed,
                         input logic [2:0] n, input logic [31:0] bytes);
    stim_row_t row;
    row.cmd         = op;
    row.cnt         = cnt;
    row.data        = data;
    row.typed       = typed;
    row.n_typed     = n;
    row.typed_bytes = bytes;
    stim_rows.push_back(row);
  endtask

  // Random word: mostly appends, with counts spread over short fields,
  // longer ones, a full data word, counts that saturate and the odd empty
  // count. Finish words come often enough to close many partial bytes.
  function automatic stim_row_t random_word();
    stim_row_t   row;
    int unsigned pick;
    row      = '0;
    row.data = $urandom;
    row.cnt  = msbp_pkg::CNT_W'($urandom_range(0, 63));
    pick     = $urandom_range(0, 99);
    if (pick < 10)      row.cmd = msbp_pkg::CMD_FINISH;
    else begin
      row.cmd = msbp_pkg::CMD_APPEND;
      if (pick < 50)      row.cnt = msbp_pkg::CNT_W'($urandom_range(1, 8));
      else if (pick < 72) row.cnt = msbp_pkg::CNT_W'($urandom_range(9, 31));
      else if (pick < 87) row.cnt = msbp_pkg::MAX_FIELD;
      else if (pick < 95) row.cnt = msbp_pkg::CNT_W'($urandom_range(33, 63));
      else                row.cnt = '0;
    end
    return row;
  endfunction

  // Result side. Every byte the block hands over is compared with the
  // oldest booked byte. Pop follows a pattern of its own: after a random
  // span it picks a new mode at random from always ready, mostly ready,
  // mostly stalled and ready on one cycle in five.
  initial begin : result_side
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    due_byte_t   due;
    logic        ready;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (due_bytes_q.size() == 0) begin
          flag_mismatch($sformatf("byte %02h with no byte booked", out_byte_o));
        end else begin
          due = due_bytes_q.pop_front();
          if (out_byte_o !== due.value)
            flag_mismatch($sformatf("out_byte %02h, wanted %02h", out_byte_o, due.value));
          if (last_o !== due.last)
            flag_mismatch($sformatf("last %b, wanted %b (byte %02h)", last_o, due.last,
                                    due.value));
        end
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 120);
      end
      span--;
      tick++;
      case (mode)
        0:       ready = 1'b1;
        1:       ready = ($urandom_range(0, 3) != 0);
        2:       ready = ($urandom_range(0, 3) == 0);
        default: ready = (tick % 5 == 0);
      endcase
      pop <= rst_ni && ready;
    end
  end

  // Sender.
  initial begin : word_side
    stim_row_t   row;
    int unsigned burst_left;

    // Directed rows. The bytes are typed in where they can be read off
    // directly; the rest are left to the packing model.
    // One whole byte from reset.
    add_row(msbp_pkg::CMD_APPEND, 6'd8,  32'h0000_00A5, 1'b1, 3'd1, 32'h0000_00A5);
    // An empty count and a finish with nothing pending make no byte.
    add_row(msbp_pkg::CMD_APPEND, 6'd0,  32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_FINISH, 6'd0,  32'h0000_0000, 1'b1, 3'd0, 32'h0);
    // A full data word is four bytes, and counts past thirty-two saturate.
    add_row(msbp_pkg::CMD_APPEND, 6'd32, 32'hDEAD_BEEF, 1'b1, 3'd4, 32'hDEAD_BEEF);
    add_row(msbp_pkg::CMD_APPEND, 6'd63, 32'h0123_4567, 1'b1, 3'd4, 32'h0123_4567);
    add_row(msbp_pkg::CMD_APPEND, 6'd33, 32'hFFFF_FFFF, 1'b1, 3'd4, 32'hFFFF_FFFF);
    // Three bits pending, then a finish whose fields must be ignored.
    add_row(msbp_pkg::CMD_APPEND, 6'd3,  32'hFFFF_FFFD, 1'b1, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_FINISH, 6'd63, 32'hFFFF_FFFF, 1'b1, 3'd1, 32'h0000_00A0);
    // Seven pending bits plus thirty-two new ones: the most one word makes.
    add_row(msbp_pkg::CMD_APPEND, 6'd7,  32'h0000_007F, 1'b1, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd32, 32'hFFFF_FFFF, 1'b1, 3'd4, 32'hFFFF_FFFF);
    add_row(msbp_pkg::CMD_FINISH, 6'd0,  32'h0000_0000, 1'b1, 3'd1, 32'h0000_00FE);
    // Single bits and a short field that just closes a byte.
    add_row(msbp_pkg::CMD_APPEND, 6'd1,  32'hFFFF_FFFF, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd1,  32'h0000_0000, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd6,  32'h0000_002A, 1'b0, 3'd0, 32'h0);
    // Zero bits crossing byte borders, the high data bit out of the field.
    add_row(msbp_pkg::CMD_APPEND, 6'd5,  32'h0000_0000, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd31, 32'h8000_0000, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_FINISH, 6'd17, 32'h1234_5678, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd32, 32'h0000_0000, 1'b1, 3'd4, 32'h0000_0000);
    // A field that completes nothing, then fields on odd bit offsets.
    add_row(msbp_pkg::CMD_APPEND, 6'd4,  32'hFFFF_FFF0, 1'b1, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd20, 32'h000A_BCDE, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd60, 32'h1357_9BDF, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_APPEND, 6'd2,  32'h0000_0003, 1'b0, 3'd0, 32'h0);
    add_row(msbp_pkg::CMD_FINISH, 6'd9,  32'hCAFE_F00D, 1'b0, 3'd0, 32'h0);
    // A second finish in a row has nothing left to flush.
    add_row(msbp_pkg::CMD_FINISH, 6'd63, 32'hFFFF_FFFF, 1'b1, 3'd0, 32'h0);

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if ($urandom_range(0, 2) == 0) idle_ticks($urandom_range(1, 4));
      send_word(stim_rows[i]);
    end
    wait_drained();

    // Random words in bursts. About one burst in four follows straight on
    // from the last, which gives stretches with no idling at all. Halfway
    // through, the sender holds off until the block has emptied.
    burst_left = 0;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) idle_ticks($urandom_range(1, 10));
      end
      if (i == RAND_WORDS / 2) wait_drained();
      row = random_word();
      send_word(row);
      burst_left--;
    end

    wait_drained();
    repeat (SETTLE_ticks) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
